### hdl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 3;
  localparam int CTRL_W   = 9;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;

  localparam logic [CTRL_W-1:0] BAS_ANY     = CTRL_W'(9'h0f << 5);
  localparam logic [CTRL_W-1:0] BAS_LOW_HW  = CTRL_W'(9'h03 << 5);
  localparam logic [CTRL_W-1:0] BAS_HIGH_HW = CTRL_W'(9'h0c << 5);
  localparam logic [CTRL_W-1:0] CTRL_EN     = CTRL_W'(9'h001);
  localparam logic [ADDR_W-1:0] ALIGN_MASK  = ~ADDR_W'(3);
  localparam logic [LEN_W-1:0]  LEN_WORD    = LEN_W'(4);

  typedef enum logic [1:0] {
    OP_SET       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_CLEAR_ALL = 2'd2,
    OP_RSVD      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } bsa_state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   bp_address;
    logic [LEN_W-1:0]    bp_length;
  } bsa_in_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [ADDR_W-1:0]   compare_value;
    logic [CTRL_W-1:0]   control_word;
    logic [CTRL_W-1:0]   slot0_control;
  } bsa_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic hit;
  } bsa_cmd_t;

  typedef struct packed {
    logic scan_op;
    logic found;
    logic exhausted;
  } bsa_sts_t;

  function automatic logic [CTRL_W-1:0] ctrl_word(input logic [ADDR_W-1:0] addr,
                                                  input logic [LEN_W-1:0] len);
    logic [CTRL_W-1:0] bas;
    if (len == LEN_WORD) begin
      bas = BAS_ANY;
    end else if (addr[1]) begin
      bas = BAS_HIGH_HW;
    end else begin
      bas = BAS_LOW_HW;
    end
    return bas | CTRL_EN;
  endfunction

endpackage

### hdl/breakpoint_slot_allocator.sv
`timescale 1ns / 1ps
// channel   ports                           accepted at
// input     start, busy, in_data            start && !busy
// result    out_valid, out_data             each cycle out_valid is high
// config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// set and clear scan the slots one per cycle through the address store read port
// a set or clear stops at the first matching slot k, or on a miss after checking all n active slots
// clear all and the unused opcode finish without a slot search; busy drops in the cycle the result shows
// synchronous active-low reset frees all slots and sets the slot count to its maximum
// the result strobe lasts one cycle and cannot be held off

module breakpoint_slot_allocator import bsa_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bsa_in_t          in_data,
  output logic             out_valid,
  output bsa_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  bsa_cmd_t cmd;
  bsa_sts_t sts;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign cfg_ready = !busy;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a request in flight");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result words");

  a_fail_zero_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DONE) |->
      (out_data.control_word == '0) && (out_data.slot_index == '0))
    else $error("failed request reported a slot");

endmodule

### hdl/bsa_ctrl.sv
`timescale 1ns / 1ps

module bsa_ctrl import bsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  bsa_sts_t sts,
  output bsa_cmd_t cmd,
  output logic     busy
);

  bsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        busy     = 1'b1;
        cmd.scan = 1'b1;
        priority if (!sts.scan_op) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.found) begin
          cmd.commit = 1'b1;
          cmd.hit    = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.exhausted) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt  = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/bsa_datapath.sv
`timescale 1ns / 1ps

module bsa_datapath import bsa_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bsa_cmd_t         cmd,
  output bsa_sts_t         sts,
  input  bsa_in_t          in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  output bsa_out_t         out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CNT_W-1:0]  n_r;
  opcode_t           op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [CTRL_W-1:0] slot0_r, slot0_nxt;
  logic [CNT_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              chk_live_r;
  logic [ADDR_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] mem [SLOTS];
  logic              out_valid_r;
  bsa_out_t          out_data_r, res_nxt;
  logic              issue;
  logic              match;
  logic              mem_we;
  logic [CTRL_W-1:0] ctrl_new;

  // active slot count, saturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CNT_W'(SLOTS);
    end else if (cfg_we) begin
      if (cfg_data > CFG_W'(SLOTS)) begin
        n_r <= CNT_W'(SLOTS);
      end else begin
        n_r <= cfg_data[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.opcode;
      addr_r <= in_data.bp_address;
      len_r  <= in_data.bp_length;
    end
  end

  assign issue = cmd.scan && (scan_idx_r < n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      chk_live_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      chk_live_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx_r <= scan_idx_r[IDX_W-1:0];
    end
  end

  // slot address store, one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
    if (mem_we) begin
      mem[chk_idx_r] <= addr_r;
    end
  end

  always_comb begin
    if (op_r == OP_SET) begin
      match = !valid_r[chk_idx_r];
    end else begin
      match = valid_r[chk_idx_r] && (rd_data_r == addr_r);
    end
  end

  assign sts.scan_op   = (op_r == OP_SET) || (op_r == OP_CLEAR);
  assign sts.found     = chk_live_r && match;
  assign sts.exhausted = !chk_live_r && (scan_idx_r >= n_r);

  assign ctrl_new = ctrl_word(addr_r, len_r);

  always_comb begin
    valid_nxt = valid_r;
    slot0_nxt = slot0_r;
    mem_we    = 1'b0;
    res_nxt   = '0;
    res_nxt.status = ST_DONE;
    unique case (op_r)
      OP_SET: begin
        if (cmd.hit) begin
          mem_we                = cmd.commit;
          valid_nxt[chk_idx_r]  = 1'b1;
          if (chk_idx_r == '0) begin
            slot0_nxt = ctrl_new;
          end
          res_nxt.slot_index    = SLOT_W'(chk_idx_r);
          res_nxt.compare_value = addr_r & ALIGN_MASK;
          res_nxt.control_word  = ctrl_new;
        end else begin
          res_nxt.status = ST_NO_FREE;
        end
      end
      OP_CLEAR: begin
        if (cmd.hit) begin
          valid_nxt[chk_idx_r] = 1'b0;
          if (chk_idx_r == '0) begin
            slot0_nxt = '0;
          end
          res_nxt.slot_index    = SLOT_W'(chk_idx_r);
          res_nxt.compare_value = addr_r & ALIGN_MASK;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR_ALL: begin
        valid_nxt = '0;
        slot0_nxt = '0;
      end
      default: begin
      end
    endcase
    res_nxt.slot0_control = slot0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      slot0_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        slot0_r <= slot0_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
